/* rtl/core/i2cmra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types, codes and constants of the register access sequencer.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

  // Default transfer length limit and device address after reset.
  localparam int        MAX_BYTES_DEF  = 8;
  localparam logic [6:0] DEV_ADDR_RST  = 7'd90;

  // Command codes carried with each tick.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Status codes reported with the done pulse.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ADDR_NAK = 2'd1;
  localparam logic [1:0] STAT_REG_NAK  = 2'd2;
  localparam logic [1:0] STAT_DATA_NAK = 2'd3;

  // Most significant bit of a byte, sent first.
  localparam logic [7:0] BYTE_MSB = 8'h80;

  // Bus phase sequencer states, one-hot.
  typedef enum logic [13:0] {
    PH_IDLE     = 14'b00000000000001,
    PH_TX_LO    = 14'b00000000000010,
    PH_TX_HI    = 14'b00000000000100,
    PH_ACK_LO   = 14'b00000000001000,
    PH_ACK_HI   = 14'b00000000010000,
    PH_RX_LO    = 14'b00000000100000,
    PH_RX_HI    = 14'b00000001000000,
    PH_MA_LO    = 14'b00000010000000,
    PH_MA_HI    = 14'b00000100000000,
    PH_STOP_LO  = 14'b00001000000000,
    PH_STOP_HI  = 14'b00010000000000,
    PH_STOP_END = 14'b00100000000000,
    PH_RESTART  = 14'b01000000000000,
    PH_START    = 14'b10000000000000
  } phase_t;

  // Which byte of the transaction is on the bus.
  typedef enum logic [1:0] {
    STG_ADDR_W = 2'd0,
    STG_REG    = 2'd1,
    STG_DATA   = 2'd2,
    STG_ADDR_R = 2'd3
  } stage_t;

  // One input tick as held in the input register.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] register_address;
    logic [3:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_t;

  // One result item.
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       write_byte_taken;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_last;
    logic       done_res;
    logic [1:0] status_code;
  } result_t;

endpackage

/* rtl/core/i2c_master_register_access_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access, top level
// Stream wrapper with input register, phase sequencer and result register.
// ----------------------------------------------------------------------------
// Each transfer on the input stream is one bus phase tick: the sampled SDA
// level plus, while idle, an optional write or read command. Each tick gives
// exactly one result transfer with the SCL and SDA levels for that phase,
// busy, the write byte fetch pulse, received bytes (read_last on m_tlast)
// and the done pulse with its status code.
// The tick is captured in an input register and its result is registered in
// the output register once that register can take it, raising m_tvalid. One
// tick is accepted per cycle when the receiver keeps m_tready high. When the
// receiver stalls, the result is held, the input register fills and s_tready
// then drops until the result is taken. The device address is written
// through cfg_we / cfg_wdata; the user must write it only while idle, as the
// block itself does not enforce this. Reset (rst, synchronous) empties both
// registers, returns the sequencer to idle and loads device address 90.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top
  import i2cmra_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: device address.
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  // Input ticks.
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] register_address, [11:8] byte_count, [19:12] write_data,
  // [20] sda_in, [23:21] zero
  input  logic [23:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  // Results.
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] scl_level, [1] sda_release, [2] busy_res, [3] write_byte_taken,
  // [4] read_valid, [12:5] read_byte, [13] done_res, [15:14] status_code
  output logic [15:0] m_tdata,
  // read_last
  output logic        m_tlast
);

  logic [6:0] dev_addr;
  logic       in_valid;
  tick_t      in_tick;
  logic       out_valid;
  result_t    out_res;
  result_t    seq_res;
  logic       step;

  // Device address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= DEV_ADDR_RST;
    end else if (cfg_we) begin
      dev_addr <= cfg_wdata;
    end
  end

  // The held tick is processed whenever the result register can take it.
  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_tick.mode             <= s_tuser;
      in_tick.register_address <= s_tdata[7:0];
      in_tick.byte_count       <= s_tdata[11:8];
      in_tick.write_data       <= s_tdata[19:12];
      in_tick.sda_in           <= s_tdata[20];
    end
  end

  i2cmra_seq #(
    .MAX_BYTES(MAX_BYTES)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .tick          (in_tick),
    .device_address(dev_addr),
    .res           (seq_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= seq_res;
    end
  end

  // Output packing.
  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.read_last;
  assign m_tdata  = {out_res.status_code, out_res.done_res, out_res.read_byte,
                     out_res.read_valid, out_res.write_byte_taken,
                     out_res.busy_res, out_res.sda_release,
                     out_res.scl_level};

endmodule

/* rtl/core/i2cmra_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access phase sequencer
// Holds the transaction state and works out one bus phase per tick.
// ----------------------------------------------------------------------------
module i2cmra_seq
  import i2cmra_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  tick_t      tick,
  input  logic [6:0] device_address,
  output result_t    res
);

  localparam int BW = $clog2(MAX_BYTES + 1);

  phase_t          phase, phase_next;
  stage_t          stage, stage_next;
  logic [2:0]      bit_counter, bit_counter_next;
  logic [7:0]      shift_byte, shift_byte_next;
  logic [BW-1:0]   bytes_left, bytes_left_next;
  logic            is_read, is_read_next;
  logic [7:0]      reg_latched, reg_latched_next;
  logic [1:0]      error_latched, error_latched_next;

  // Next state and result for the phase of this tick.
  always_comb begin
    logic [BW-1:0] cnt;
    logic [BW-1:0] left_dec;
    logic [7:0]    rx_byte;
    logic          last_byte;

    phase_next         = phase;
    stage_next         = stage;
    bit_counter_next   = bit_counter;
    shift_byte_next    = shift_byte;
    bytes_left_next    = bytes_left;
    is_read_next       = is_read;
    reg_latched_next   = reg_latched;
    error_latched_next = error_latched;

    if (32'(tick.byte_count) > MAX_BYTES) begin
      cnt = BW'(MAX_BYTES);
    end else begin
      cnt = BW'(tick.byte_count);
    end
    if (stage == STG_DATA && bytes_left != '0) begin
      left_dec = bytes_left - BW'(1);
    end else begin
      left_dec = bytes_left;
    end
    rx_byte   = {shift_byte[6:0], tick.sda_in};
    last_byte = (bytes_left <= BW'(1));

    res = '0;
    res.scl_level   = 1'b1;
    res.sda_release = 1'b1;
    res.busy_res    = 1'b1;

    unique case (phase)
      PH_IDLE: begin
        res.busy_res = 1'b0;
        if (tick.mode == MODE_WRITE || tick.mode == MODE_READ) begin
          res.busy_res       = 1'b1;
          res.sda_release    = 1'b0;
          is_read_next       = (tick.mode == MODE_READ);
          reg_latched_next   = tick.register_address;
          if (tick.mode == MODE_READ && cnt == '0) begin
            bytes_left_next = BW'(1);
          end else begin
            bytes_left_next = cnt;
          end
          error_latched_next = STAT_OK;
          bit_counter_next   = '0;
          stage_next         = STG_ADDR_W;
          shift_byte_next    = {device_address, 1'b0};
          phase_next         = PH_TX_LO;
        end
      end
      PH_TX_LO: begin
        res.scl_level   = 1'b0;
        res.sda_release = |(shift_byte & BYTE_MSB);
        phase_next      = PH_TX_HI;
      end
      PH_TX_HI: begin
        res.sda_release  = |(shift_byte & BYTE_MSB);
        shift_byte_next  = {shift_byte[6:0], 1'b0};
        bit_counter_next = bit_counter + 3'd1;
        phase_next       = (bit_counter == 3'd7) ? PH_ACK_LO : PH_TX_LO;
      end
      PH_ACK_LO: begin
        res.scl_level = 1'b0;
        phase_next    = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        if (tick.sda_in) begin
          // No acknowledge: record which byte failed and stop.
          if (stage == STG_ADDR_W) begin
            error_latched_next = STAT_ADDR_NAK;
          end else if (stage == STG_REG) begin
            error_latched_next = STAT_REG_NAK;
          end else begin
            error_latched_next = STAT_DATA_NAK;
          end
          phase_next = PH_STOP_LO;
        end else if (stage == STG_ADDR_W) begin
          shift_byte_next = reg_latched;
          stage_next      = STG_REG;
          phase_next      = PH_TX_LO;
        end else if (stage == STG_ADDR_R) begin
          shift_byte_next  = '0;
          bit_counter_next = '0;
          phase_next       = PH_RX_LO;
        end else if (stage == STG_REG && is_read) begin
          phase_next = PH_STOP_LO;
        end else begin
          // Write path: fetch the next data byte or finish.
          bytes_left_next = left_dec;
          if (left_dec != '0) begin
            shift_byte_next      = tick.write_data;
            res.write_byte_taken = 1'b1;
            stage_next           = STG_DATA;
            phase_next           = PH_TX_LO;
          end else begin
            phase_next = PH_STOP_LO;
          end
        end
      end
      PH_RX_LO: begin
        res.scl_level = 1'b0;
        phase_next    = PH_RX_HI;
      end
      PH_RX_HI: begin
        shift_byte_next  = rx_byte;
        bit_counter_next = bit_counter + 3'd1;
        if (bit_counter == 3'd7) begin
          res.read_valid = 1'b1;
          res.read_byte  = rx_byte;
          res.read_last  = last_byte;
          phase_next     = PH_MA_LO;
        end else begin
          phase_next = PH_RX_LO;
        end
      end
      PH_MA_LO: begin
        res.scl_level   = 1'b0;
        res.sda_release = last_byte;
        phase_next      = PH_MA_HI;
      end
      PH_MA_HI: begin
        res.sda_release = last_byte;
        if (last_byte) begin
          bytes_left_next = '0;
          phase_next      = PH_STOP_LO;
        end else begin
          bytes_left_next  = bytes_left - BW'(1);
          shift_byte_next  = '0;
          bit_counter_next = '0;
          phase_next       = PH_RX_LO;
        end
      end
      PH_STOP_LO: begin
        res.scl_level   = 1'b0;
        res.sda_release = 1'b0;
        phase_next      = PH_STOP_HI;
      end
      PH_STOP_HI: begin
        res.sda_release = 1'b0;
        if (stage == STG_REG && is_read && error_latched == STAT_OK) begin
          phase_next = PH_RESTART;
        end else begin
          phase_next = PH_STOP_END;
        end
      end
      PH_STOP_END: begin
        res.done_res    = 1'b1;
        res.status_code = error_latched;
        phase_next      = PH_IDLE;
      end
      PH_RESTART: begin
        phase_next = PH_START;
      end
      PH_START: begin
        res.sda_release  = 1'b0;
        shift_byte_next  = {device_address, 1'b1};
        stage_next       = STG_ADDR_R;
        bit_counter_next = '0;
        phase_next       = PH_TX_LO;
      end
      default: begin
        // Corrupt state code: fall back to idle.
        res.busy_res = 1'b0;
        phase_next   = PH_IDLE;
      end
    endcase
  end

  // State registers advance once per consumed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      stage         <= STG_ADDR_W;
      bit_counter   <= '0;
      shift_byte    <= '0;
      bytes_left    <= '0;
      is_read       <= 1'b0;
      reg_latched   <= '0;
      error_latched <= STAT_OK;
    end else if (step) begin
      phase         <= phase_next;
      stage         <= stage_next;
      bit_counter   <= bit_counter_next;
      shift_byte    <= shift_byte_next;
      bytes_left    <= bytes_left_next;
      is_read       <= is_read_next;
      reg_latched   <= reg_latched_next;
      error_latched <= error_latched_next;
    end
  end

endmodule

/* verif/i2c_master_register_access_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access checker
// Watches the configuration port and both streams, runs its own model of the
// phase sequencer on every accepted tick and compares each result transfer
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module i2c_master_register_access_checker
  import i2cmra_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [7:0] register_address, [11:8] byte_count, [19:12] write_data,
  // [20] sda_in, [23:21] zero
  input  logic [23:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [0] scl_level, [1] sda_release, [2] busy_res, [3] write_byte_taken,
  // [4] read_valid, [12:5] read_byte, [13] done_res, [15:14] status_code
  input  logic [15:0] m_tdata,
  // read_last
  input  logic        m_tlast,
  output int          mismatch_count,
  output int          results_owed
);

  localparam int REPORT_LIMIT = 10;

  // Model state of the sequencer and its device address copy.
  phase_t     seq_phase;
  stage_t     seq_stage;
  logic [2:0] seq_bit;
  logic [7:0] seq_shift;
  logic [3:0] seq_left;
  logic       seq_read;
  logic [7:0] seq_reg;
  logic [1:0] seq_err;
  logic [6:0] dev_addr;

  // Bus phases predicted but not yet seen on the result stream.
  result_t    phase_line_q[$];
  int         errors = 0;

  assign mismatch_count = errors;

  function automatic string describe(input result_t r);
    return $sformatf({"scl=%0b sda=%0b busy=%0b taken=%0b rvalid=%0b ",
                      "rbyte=%02h rlast=%0b done=%0b status=%0d"},
                     r.scl_level, r.sda_release, r.busy_res, r.write_byte_taken,
                     r.read_valid, r.read_byte, r.read_last, r.done_res,
                     r.status_code);
  endfunction

  // Advances the model by one bus phase and gives the line levels and flags.
  task automatic step_sequencer(input tick_t t, output result_t r);
    logic [3:0] cnt;
    logic [2:0] prev_bit;
    r             = '0;
    r.scl_level   = 1'b1;
    r.sda_release = 1'b1;
    r.busy_res    = 1'b1;
    cnt           = t.byte_count;
    case (seq_phase)
      PH_IDLE: begin
        r.busy_res = 1'b0;
        if (t.mode == MODE_WRITE || t.mode == MODE_READ) begin
          r.busy_res    = 1'b1;
          r.sda_release = 1'b0;
          seq_read      = (t.mode == MODE_READ);
          seq_reg       = t.register_address;
          if (cnt > MAX_BYTES) cnt = 4'(MAX_BYTES);
          if (seq_read && cnt == 4'd0) cnt = 4'd1;
          seq_left  = cnt;
          seq_err   = STAT_OK;
          seq_bit   = 3'd0;
          seq_stage = STG_ADDR_W;
          seq_shift = {dev_addr, 1'b0};
          seq_phase = PH_TX_LO;
        end
      end
      PH_TX_LO: begin
        r.scl_level   = 1'b0;
        r.sda_release = seq_shift[7];
        seq_phase     = PH_TX_HI;
      end
      PH_TX_HI: begin
        r.sda_release = seq_shift[7];
        seq_shift     = {seq_shift[6:0], 1'b0};
        prev_bit      = seq_bit;
        seq_bit       = seq_bit + 3'd1;
        seq_phase     = (prev_bit == 3'd7) ? PH_ACK_LO : PH_TX_LO;
      end
      PH_ACK_LO: begin
        r.scl_level = 1'b0;
        seq_phase   = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        if (t.sda_in) begin
          // No acknowledge: the code depends on which byte was refused.
          seq_err   = (seq_stage == STG_ADDR_W) ? STAT_ADDR_NAK :
                      (seq_stage == STG_REG) ? STAT_REG_NAK : STAT_DATA_NAK;
          seq_phase = PH_STOP_LO;
        end else if (seq_stage == STG_ADDR_W) begin
          seq_shift = seq_reg;
          seq_stage = STG_REG;
          seq_phase = PH_TX_LO;
        end else if (seq_stage == STG_ADDR_R) begin
          seq_shift = 8'h00;
          seq_bit   = 3'd0;
          seq_phase = PH_RX_LO;
        end else if (seq_stage == STG_REG && seq_read) begin
          seq_phase = PH_STOP_LO;
        end else begin
          if (seq_stage == STG_DATA && seq_left > 4'd0) seq_left = seq_left - 4'd1;
          if (seq_left > 4'd0) begin
            seq_shift          = t.write_data;
            r.write_byte_taken = 1'b1;
            seq_stage          = STG_DATA;
            seq_phase          = PH_TX_LO;
          end else begin
            seq_phase = PH_STOP_LO;
          end
        end
      end
      PH_RX_LO: begin
        r.scl_level = 1'b0;
        seq_phase   = PH_RX_HI;
      end
      PH_RX_HI: begin
        seq_shift = {seq_shift[6:0], t.sda_in};
        prev_bit  = seq_bit;
        seq_bit   = seq_bit + 3'd1;
        if (prev_bit == 3'd7) begin
          r.read_valid = 1'b1;
          r.read_byte  = seq_shift;
          r.read_last  = (seq_left <= 4'd1);
          seq_phase    = PH_MA_LO;
        end else begin
          seq_phase = PH_RX_LO;
        end
      end
      PH_MA_LO: begin
        r.scl_level   = 1'b0;
        r.sda_release = (seq_left <= 4'd1);
        seq_phase     = PH_MA_HI;
      end
      PH_MA_HI: begin
        r.sda_release = (seq_left <= 4'd1);
        if (seq_left <= 4'd1) begin
          seq_left  = 4'd0;
          seq_phase = PH_STOP_LO;
        end else begin
          seq_left  = seq_left - 4'd1;
          seq_shift = 8'h00;
          seq_bit   = 3'd0;
          seq_phase = PH_RX_LO;
        end
      end
      PH_STOP_LO: begin
        r.scl_level   = 1'b0;
        r.sda_release = 1'b0;
        seq_phase     = PH_STOP_HI;
      end
      PH_STOP_HI: begin
        r.sda_release = 1'b0;
        // A read that got its register byte through goes on with a restart.
        if (seq_stage == STG_REG && seq_read && seq_err == STAT_OK) seq_phase = PH_RESTART;
        else seq_phase = PH_STOP_END;
      end
      PH_STOP_END: begin
        r.done_res    = 1'b1;
        r.status_code = seq_err;
        seq_phase     = PH_IDLE;
      end
      PH_RESTART: begin
        seq_phase = PH_START;
      end
      PH_START: begin
        r.sda_release = 1'b0;
        seq_shift     = {dev_addr, 1'b1};
        seq_stage     = STG_ADDR_R;
        seq_bit       = 3'd0;
        seq_phase     = PH_TX_LO;
      end
      default: begin
        r.busy_res = 1'b0;
        seq_phase  = PH_IDLE;
      end
    endcase
  endtask

  // Compare finished transfers first, then predict the newly accepted tick.
  always @(posedge clk) begin : watch
    tick_t   t;
    result_t want;
    result_t got;
    if (rst) begin
      seq_phase = PH_IDLE;
      seq_stage = STG_ADDR_W;
      seq_bit   = 3'd0;
      seq_shift = 8'h00;
      seq_left  = 4'd0;
      seq_read  = 1'b0;
      seq_reg   = 8'h00;
      seq_err   = STAT_OK;
      dev_addr  = DEV_ADDR_RST;
      phase_line_q.delete();
      results_owed <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.scl_level        = m_tdata[0];
        got.sda_release      = m_tdata[1];
        got.busy_res         = m_tdata[2];
        got.write_byte_taken = m_tdata[3];
        got.read_valid       = m_tdata[4];
        got.read_byte        = m_tdata[12:5];
        got.read_last        = m_tlast;
        got.done_res         = m_tdata[13];
        got.status_code      = m_tdata[15:14];
        if (phase_line_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: %s", $realtime, describe(got));
        end else begin
          want = phase_line_q.pop_front();
          // The packed compare covers every field, X and Z included.
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: mismatch, expected %s", $realtime, describe(want));
              $display("%0t: mismatch, actual   %s", $realtime, describe(got));
            end
          end
        end
      end
      if (cfg_we) dev_addr = cfg_wdata;
      if (s_tvalid && s_tready) begin
        t.mode             = s_tuser;
        t.register_address = s_tdata[7:0];
        t.byte_count       = s_tdata[11:8];
        t.write_data       = s_tdata[19:12];
        t.sda_in           = s_tdata[20];
        step_sequencer(t, want);
        phase_line_q.push_back(want);
      end
      results_owed <= phase_line_q.size();
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access testbench
// Drives bus phase ticks shaped as whole register transactions with a slave
// that mostly acknowledges, across several device addresses and idle
// patterns on both streams, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cmra_pkg::*;

  // Command code that the block treats as a plain tick.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // How busy ticks fill their free fields.
  localparam int FILL_RANDOM = 0;
  localparam int FILL_LOW    = 1;
  localparam int FILL_HIGH   = 2;

  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_TICKS = 30;
  localparam int DRAIN_TICKS = 60;
  localparam int NUM_PHASES  = 4;
  localparam int TX_IDLE_PCT [NUM_PHASES] = '{0, 64, 0, 18};
  localparam int RX_STALL_PCT[NUM_PHASES] = '{0, 0, 64, 18};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic [23:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = MODE_TICK;
  logic        m_tready  = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;
  logic        m_tlast;

  int mismatch_count;
  int results_owed;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int nak_pct       = 0;
  int level_fill    = FILL_RANDOM;
  int hold_req_cnt  = 0;
  int hold_done_cnt = 0;
  int ticks_sent    = 0;

  always #2 clk = ~clk;

  i2c_master_register_access_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  i2c_master_register_access_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // Result receiver: random stalls, plus a long hold-off whenever one is asked.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_done_cnt != hold_req_cnt) begin
        hold_left     = HOLD_CYCLES;
        hold_done_cnt = hold_done_cnt + 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic [7:0] fill_byte();
    case (level_fill)
      FILL_LOW:  return 8'h00;
      FILL_HIGH: return 8'hFF;
      default:   return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic fill_bit();
    case (level_fill)
      FILL_LOW:  return 1'b0;
      FILL_HIGH: return 1'b1;
      default:   return 1'($urandom_range(1));
    endcase
  endfunction

  // Offers one tick after a random gap and waits for its transfer.
  task automatic offer_tick(input logic [1:0] mode, input logic [7:0] reg_num,
                            input logic [3:0] cnt, input logic [7:0] wd, input logic sda);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {3'b000, sda, wd, cnt, reg_num};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
  endtask

  // Ticks during a transaction: any mode, since commands are ignored while busy.
  task automatic busy_ticks(input int n);
    logic [7:0] r8;
    logic [7:0] c8;
    logic [7:0] w8;
    repeat (n) begin
      r8 = fill_byte();
      c8 = fill_byte();
      w8 = fill_byte();
      offer_tick(2'($urandom_range(3)), r8, c8[3:0], w8, fill_bit());
    end
  endtask

  // Ticks while idle that start nothing; they do not count as work.
  task automatic plain_ticks(input int n);
    logic [7:0] c8;
    repeat (n) begin
      c8 = 8'($urandom_range(255));
      offer_tick($urandom_range(1) ? MODE_SPARE : MODE_TICK, 8'($urandom_range(255)),
                 c8[3:0], 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    ticks_sent -= n;
  endtask

  // One byte on the bus: 16 bit phases, the ACK low phase, then the ACK sample.
  task automatic byte_slot(input bit force_nak, output bit nak);
    logic [7:0] r8;
    logic [7:0] c8;
    logic [7:0] w8;
    busy_ticks(17);
    nak = force_nak || ($urandom_range(99) < nak_pct);
    r8  = fill_byte();
    c8  = fill_byte();
    w8  = fill_byte();
    offer_tick(2'($urandom_range(3)), r8, c8[3:0], w8, nak);
  endtask

  // Register write; slot 0 is the address, 1 the register, then the data bytes.
  task automatic run_write(input logic [7:0] reg_num, input logic [3:0] cnt,
                           input int nak_at);
    int nbytes;
    int slot;
    bit nak;
    offer_tick(MODE_WRITE, reg_num, cnt, fill_byte(), fill_bit());
    nbytes = (cnt > MAX_BYTES_DEF) ? MAX_BYTES_DEF : cnt;
    nak    = 1'b0;
    for (slot = 0; slot < nbytes + 2 && !nak; slot++) byte_slot(slot == nak_at, nak);
    busy_ticks(3);
  endtask

  // Register read; slot 0 is the address, 1 the register, 2 the read address.
  task automatic run_read(input logic [7:0] reg_num, input logic [3:0] cnt,
                          input int nak_at);
    int nbytes;
    bit nak;
    offer_tick(MODE_READ, reg_num, cnt, fill_byte(), fill_bit());
    nbytes = (cnt > MAX_BYTES_DEF) ? MAX_BYTES_DEF : ((cnt == 4'd0) ? 1 : cnt);
    byte_slot(nak_at == 0, nak);
    if (!nak) byte_slot(nak_at == 1, nak);
    if (!nak) begin
      // Stop, restart, then the address with the read bit.
      busy_ticks(4);
      byte_slot(nak_at == 2, nak);
      if (!nak) busy_ticks(18 * nbytes);
    end
    busy_ticks(3);
  endtask

  // Sender pause until every predicted result has been transferred.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_address(input logic [6:0] addr);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // One random step: mostly transactions of small sizes, some noise and pauses.
  task automatic random_txn();
    int pick;
    int sz;
    logic [3:0] cnt;
    pick = $urandom_range(99);
    sz   = $urandom_range(99);
    cnt  = (sz < 70) ? 4'($urandom_range(3)) :
           (sz < 90) ? 4'($urandom_range(8, 4)) : 4'($urandom_range(15, 9));
    if (pick < 6) settle();
    else if (pick < 14) plain_ticks($urandom_range(5, 1));
    else if (pick < 57) run_write(8'($urandom_range(255)), cnt, -1);
    else run_read(8'($urandom_range(255)), cnt, -1);
  endtask

  initial begin : stimulus
    int ph;
    int phase_end;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases at the reset device address.
    offer_tick(MODE_TICK, 8'h00, 4'd0, 8'h00, 1'b0);
    offer_tick(MODE_SPARE, 8'hFF, 4'hF, 8'hFF, 1'b1);
    run_write(8'h00, 4'd0, -1);
    level_fill = FILL_HIGH;
    run_write(8'hFF, 4'd3, -1);
    run_read(8'hFF, 4'd3, -1);
    level_fill = FILL_LOW;
    run_write(8'h00, 4'd15, -1);
    run_read(8'h00, 4'd15, -1);
    level_fill = FILL_RANDOM;
    run_read(8'($urandom_range(255)), 4'd0, -1);
    run_read(8'($urandom_range(255)), 4'd1, -1);
    // Refused address and register bytes, data byte (write) and read address (read).
    run_write(8'($urandom_range(255)), 4'd2, 0);
    run_write(8'($urandom_range(255)), 4'd2, 1);
    run_write(8'($urandom_range(255)), 4'd3, 3);
    run_read(8'($urandom_range(255)), 4'd2, 0);
    run_read(8'($urandom_range(255)), 4'd2, 1);
    run_read(8'($urandom_range(255)), 4'd2, 2);

    // Random phases, each with its own address and idle pattern.
    nak_pct = 4;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_address((ph == 0) ? 7'd0 : (ph == 1) ? 7'h7F : 7'($urandom_range(127)));
      tx_idle_pct  = TX_IDLE_PCT[ph];
      rx_stall_pct = RX_STALL_PCT[ph];
      if (ph == 0) begin
        // Long receiver hold-off while a full-length read keeps the input busy.
        hold_req_cnt = hold_req_cnt + 1;
        run_read(8'($urandom_range(255)), 4'd8, -1);
      end
      phase_end = ticks_sent + PHASE_TICKS;
      while (ticks_sent < phase_end) random_txn();
      // Unshaped ticks, then plain ticks that let most transactions run out.
      busy_ticks(16);
      plain_ticks(DRAIN_TICKS);
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin : watchdog
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
rtl/core/i2cmra_pkg.sv
rtl/core/i2cmra_seq.sv
rtl/core/i2c_master_register_access_top.sv
verif/i2c_master_register_access_checker.sv
verif/tb_top.sv
